/* rtl/core/midi_controller_expander_unit_assert.svh */
// Assertion macros for the controller expander.
// MCEU_ASSERT checks a property, MCEU_ASSERT_NEVER checks that a condition never holds.
`ifndef MIDI_CONTROLLER_EXPANDER_UNIT_ASSERT_SVH
`define MIDI_CONTROLLER_EXPANDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MCEU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
`define MCEU_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define MCEU_ASSERT(name, clk, rst, prop)
`define MCEU_ASSERT_NEVER(name, clk, rst, cond)
`endif
`endif

/* rtl/core/mce_pkg.sv */
package mce_pkg;

   // cache geometry, index width must keep the entry count a power of two
   localparam int CACHE_INDEX_W = 10;
   localparam int CACHE_ENTRIES = 1 << CACHE_INDEX_W;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [7:0] CTRL_EVENT = 8'd176;
   localparam logic [7:0] ST_CC      = 8'hB0;
   localparam logic [7:0] ST_PROGRAM = 8'hC0;
   localparam logic [7:0] ST_PITCH   = 8'hE0;
   localparam logic [7:0] ST_SYSEX   = 8'hF0;

   localparam logic [18:0] CC_BANK_H = 19'd0;
   localparam logic [18:0] CC_BANK_L = 19'd32;
   localparam logic [18:0] CC_DATA_H = 19'd6;
   localparam logic [18:0] CC_DATA_L = 19'd38;
   localparam logic [18:0] CC_NRPN_L = 19'd98;
   localparam logic [18:0] CC_NRPN_H = 19'd99;
   localparam logic [18:0] CC_RPN_L  = 19'd100;
   localparam logic [18:0] CC_RPN_H  = 19'd101;

   // class boundaries of the controller number
   localparam logic [18:0] CLASS_CC14_BASE   = 19'h01000;
   localparam logic [18:0] CLASS_RPN_BASE    = 19'h20000;
   localparam logic [18:0] CLASS_NRPN_BASE   = 19'h30000;
   localparam logic [18:0] CLASS_RPN14_BASE  = 19'h40000;
   localparam logic [18:0] CLASS_NRPN14_BASE = 19'h60000;
   localparam logic [18:0] CLASS_NONE_BASE   = 19'h70000;

   localparam logic [7:0] BANK_NONE = 8'hFF;

   typedef enum logic [1:0] {
      CSR_DEVICE_ID,
      CSR_PITCH_CTRL,
      CSR_PROGRAM_CTRL,
      CSR_MVOL_CTRL
   } csr_index_type;

   typedef enum logic [2:0] {
      MSG_CC      = 3'd0,
      MSG_PROGRAM = 3'd1,
      MSG_PITCH   = 3'd2,
      MSG_SYSEX   = 3'd3,
      MSG_PASS    = 3'd4
   } msg_code_type;

   typedef enum logic [3:0] {
      KIND_PASS,
      KIND_PITCH,
      KIND_PROGRAM,
      KIND_MVOL,
      KIND_CC7,
      KIND_CC14,
      KIND_RPN,
      KIND_NRPN,
      KIND_RPN14,
      KIND_NRPN14,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      logic [7:0]  event_type;
      logic [4:0]  channel;
      logic [18:0] ctrl_number;
      logic [23:0] ctrl_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  message;
      logic [7:0]  out_type;
      logic [4:0]  out_channel;
      logic [18:0] out_data_a;
      logic [23:0] out_data_b;
      logic [6:0]  out_device_id;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  device_id;
      logic [18:0] pitch_ctrl_number;
      logic [18:0] program_ctrl_number;
      logic [18:0] master_volume_ctrl_number;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  event_type;
      logic [4:0]  channel;
      logic [18:0] ctrl_number;
      logic [23:0] ctrl_value;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cmdq_status_type;

   typedef struct packed {
      logic        valid;
      logic [23:0] key;
      logic [23:0] value;
   } cache_entry_type;

   // one bit per message slot, slot 0 goes out first
   function automatic logic [3:0] slot_mask(input cmd_type c);
      logic [3:0] m;
      case (c.kind)
         KIND_PASS, KIND_PITCH, KIND_MVOL, KIND_CC7: m = 4'b0001;
         KIND_CC14:                                  m = 4'b0011;
         KIND_RPN, KIND_NRPN:                        m = 4'b0111;
         KIND_RPN14, KIND_NRPN14:                    m = 4'b1111;
         KIND_PROGRAM: begin
            m = {1'b0, 1'b1, c.ctrl_value[15:8] != BANK_NONE,
                 c.ctrl_value[23:16] != BANK_NONE};
         end
         default:                                    m = 4'b0000;
      endcase
      return m;
   endfunction

   function automatic rsp_type make_msg(input msg_code_type code, input logic [7:0] st,
                                        input logic [4:0] chn, input logic [18:0] da,
                                        input logic [23:0] db);
      rsp_type r;
      r.message       = code;
      r.out_type      = st;
      r.out_channel   = chn;
      r.out_data_a    = da;
      r.out_data_b    = db;
      r.out_device_id = '0;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic rsp_type expand_slot(input cmd_type c, input logic [1:0] slot);
      logic [18:0] a;
      logic [23:0] b;
      logic [4:0]  chn;
      logic [18:0] ch_h_num;
      logic [18:0] ch_l_num;
      logic [23:0] ch_h_val;
      logic [23:0] ch_l_val;
      logic [23:0] d_h;
      logic [23:0] d_l;
      logic [18:0] par_h;
      logic [18:0] par_l;
      rsp_type     r;
      a        = c.ctrl_number;
      b        = c.ctrl_value;
      chn      = c.channel;
      ch_h_num = {12'd0, a[14:8]};
      ch_l_num = {12'd0, a[6:0]};
      ch_h_val = {17'd0, a[14:8]};
      ch_l_val = {17'd0, a[6:0]};
      d_h      = {17'd0, b[13:7]};
      d_l      = {17'd0, b[6:0]};
      par_h    = (c.kind == KIND_RPN || c.kind == KIND_RPN14) ? CC_RPN_H : CC_NRPN_H;
      par_l    = (c.kind == KIND_RPN || c.kind == KIND_RPN14) ? CC_RPN_L : CC_NRPN_L;
      case (c.kind)
         KIND_PASS:  r = make_msg(MSG_PASS, c.event_type, chn, a, b);
         KIND_PITCH: r = make_msg(MSG_PITCH, ST_PITCH, chn, b[18:0], 24'd0);
         KIND_MVOL:  r = make_msg(MSG_SYSEX, ST_SYSEX, 5'd0, {12'd0, b[6:0]}, d_h);
         KIND_CC7:   r = make_msg(MSG_CC, ST_CC, chn, a, b);
         KIND_PROGRAM: begin
            case (slot)
               2'd0:    r = make_msg(MSG_CC, ST_CC, chn, CC_BANK_H, {16'd0, b[23:16]});
               2'd1:    r = make_msg(MSG_CC, ST_CC, chn, CC_BANK_L, {16'd0, b[15:8]});
               default: r = make_msg(MSG_PROGRAM, ST_PROGRAM, chn, {12'd0, b[6:0]}, 24'd0);
            endcase
         end
         KIND_CC14: begin
            case (slot)
               2'd0:    r = make_msg(MSG_CC, ST_CC, chn, ch_h_num, d_h);
               default: r = make_msg(MSG_CC, ST_CC, chn, ch_l_num, d_l);
            endcase
         end
         KIND_RPN, KIND_NRPN: begin
            case (slot)
               2'd0:    r = make_msg(MSG_CC, ST_CC, chn, par_h, ch_h_val);
               2'd1:    r = make_msg(MSG_CC, ST_CC, chn, par_l, ch_l_val);
               default: r = make_msg(MSG_CC, ST_CC, chn, CC_DATA_H, b);
            endcase
         end
         KIND_RPN14, KIND_NRPN14: begin
            case (slot)
               2'd0:    r = make_msg(MSG_CC, ST_CC, chn, par_h, ch_h_val);
               2'd1:    r = make_msg(MSG_CC, ST_CC, chn, par_l, ch_l_val);
               2'd2:    r = make_msg(MSG_CC, ST_CC, chn, CC_DATA_H, d_h);
               default: r = make_msg(MSG_CC, ST_CC, chn, CC_DATA_L, d_l);
            endcase
         end
         default: r = make_msg(MSG_PASS, c.event_type, chn, a, b);
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/midi_controller_expander_unit.sv */
// Controller expander. Words enter through push/full and results leave through
// empty/pop, one result word per cycle while pop is held. A non-controller word
// passes through as one result; a controller word is checked against a
// direct-mapped cache of the last value sent per channel and controller, and an
// unchanged value produces nothing. Otherwise it expands into one to four
// messages, the final one marked by last, or none if its number has no class.
// The lookup stage takes a new word every cycle while the queue has room; the
// expander emits one message per cycle while pop is held, and a four-entry
// command queue absorbs bursts. A word passes the lookup stage, the queue, the
// current-command and output registers. After reset all 1024 cache entries are
// cleared one per cycle while full stays high; register writes are still taken.
module midi_controller_expander_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  mce_pkg::req_type       req_data,
   output logic                   empty,
   input  logic                   pop,
   output mce_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  mce_pkg::csr_index_type csr_index,
   input  logic [18:0]            csr_wdata
);
   import mce_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   cmdq_status_type q_status;
   logic            q_push;
   cmd_type         q_cmd;
   logic            q_pop;
   cmd_type         q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ID:    cfg_in.device_id                 = csr_wdata[6:0];
            CSR_PITCH_CTRL:   cfg_in.pitch_ctrl_number         = csr_wdata;
            CSR_PROGRAM_CTRL: cfg_in.program_ctrl_number       = csr_wdata;
            CSR_MVOL_CTRL:    cfg_in.master_volume_ctrl_number = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id                 <= 7'd127;
         cfg_ff.pitch_ctrl_number         <= 19'd262144;
         cfg_ff.program_ctrl_number       <= 19'd262145;
         cfg_ff.master_volume_ctrl_number <= 19'd262146;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mce_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_status (q_status),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   mce_cmd_fifo u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .status   (q_status)
   );

   mce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .device_id (cfg_ff.device_id),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/mce_ram.sv */
module mce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mce_front.sv */
`include "midi_controller_expander_unit_assert.svh"

module mce_front (
   input  logic                     clock,
   input  logic                     reset,
   input  mce_pkg::cfg_type         cfg,
   input  logic                     push,
   output logic                     full,
   input  mce_pkg::req_type         req_data,
   input  mce_pkg::cmdq_status_type q_status,
   output logic                     q_push,
   output mce_pkg::cmd_type         q_cmd
);
   import mce_pkg::*;

   localparam int EntryW = $bits(cache_entry_type);

   logic                     accept;
   logic [18:0]              req_hash;
   logic [CACHE_INDEX_W-1:0] rd_idx;

   logic                     clr_active_ff, clr_active_in;
   logic [CACHE_INDEX_W-1:0] clr_idx_ff, clr_idx_in;

   logic                     s1_valid_ff, s1_valid_in;
   req_type                  s1_item_ff;
   logic [CACHE_INDEX_W-1:0] s1_idx_ff;
   logic                     fwd_hit_ff;
   cache_entry_type          fwd_entry_ff;

   logic [EntryW-1:0]        ram_rd_data;
   cache_entry_type          entry;
   logic                     is_ctrl;
   logic [23:0]              s1_key;
   logic                     cache_hit;
   kind_type                 kind;
   logic                     advance;

   logic                     wr_en;
   logic [CACHE_INDEX_W-1:0] wr_addr;
   cache_entry_type          wr_entry;

   assign accept   = push && !full;
   assign req_hash = req_data.ctrl_number ^ {9'd0, req_data.channel, 5'd0};
   assign rd_idx   = req_hash[CACHE_INDEX_W-1:0];

   // clearing sweep after reset: one entry per cycle
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == CACHE_INDEX_W'(CACHE_ENTRIES - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   assign entry   = fwd_hit_ff ? fwd_entry_ff : cache_entry_type'(ram_rd_data);
   assign is_ctrl = s1_item_ff.event_type == CTRL_EVENT;
   assign s1_key  = {s1_item_ff.channel, s1_item_ff.ctrl_number};
   assign cache_hit = is_ctrl && entry.valid && entry.key == s1_key &&
                      entry.value == s1_item_ff.ctrl_value;

   always_comb begin
      logic [18:0] a;
      a = s1_item_ff.ctrl_number;
      if (!is_ctrl) begin
         kind = KIND_PASS;
      end else if (a == cfg.pitch_ctrl_number) begin
         kind = KIND_PITCH;
      end else if (a == cfg.program_ctrl_number) begin
         kind = KIND_PROGRAM;
      end else if (a == cfg.master_volume_ctrl_number) begin
         kind = KIND_MVOL;
      end else if (a < CLASS_CC14_BASE) begin
         kind = KIND_CC7;
      end else if (a < CLASS_RPN_BASE) begin
         kind = KIND_CC14;
      end else if (a < CLASS_NRPN_BASE) begin
         kind = KIND_RPN;
      end else if (a < CLASS_RPN14_BASE) begin
         kind = KIND_NRPN;
      end else if (a < CLASS_NRPN14_BASE) begin
         kind = KIND_RPN14;
      end else if (a < CLASS_NONE_BASE) begin
         kind = KIND_NRPN14;
      end else begin
         kind = KIND_NONE;
      end
   end

   // a word leaves the lookup stage only when the queue has room
   assign advance = s1_valid_ff && !q_status.full;
   assign full    = clr_active_ff || (s1_valid_ff && q_status.full);

   assign q_push           = advance && !cache_hit && kind != KIND_NONE;
   assign q_cmd.kind        = kind;
   assign q_cmd.event_type  = s1_item_ff.event_type;
   assign q_cmd.channel     = s1_item_ff.channel;
   assign q_cmd.ctrl_number = s1_item_ff.ctrl_number;
   assign q_cmd.ctrl_value  = s1_item_ff.ctrl_value;

   always_comb begin
      if (clr_active_ff) begin
         wr_en          = 1'b1;
         wr_addr        = clr_idx_ff;
         wr_entry.valid = 1'b0;
         wr_entry.key   = '0;
         wr_entry.value = '0;
      end else begin
         wr_en          = advance && is_ctrl && !cache_hit;
         wr_addr        = s1_idx_ff;
         wr_entry.valid = 1'b1;
         wr_entry.key   = s1_key;
         wr_entry.value = s1_item_ff.ctrl_value;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // the RAM read misses a write landing on the same edge: keep that write
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff   <= req_data;
         s1_idx_ff    <= rd_idx;
         fwd_hit_ff   <= wr_en && (wr_addr == rd_idx);
         fwd_entry_ff <= wr_entry;
      end
   end

   mce_ram #(
      .WIDTH (EntryW),
      .DEPTH (CACHE_ENTRIES)
   ) u_cache (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   `MCEU_ASSERT(a_no_lookup_while_clearing, clock, reset, clr_active_ff |-> !s1_valid_ff)

endmodule

/* rtl/core/mce_cmd_fifo.sv */
`include "midi_controller_expander_unit_assert.svh"

module mce_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mce_pkg::cmd_type         push_cmd,
   input  logic                     pop,
   output mce_pkg::cmd_type         head_cmd,
   output mce_pkg::cmdq_status_type status
);
   import mce_pkg::*;

   cmd_type               mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CMDQ_CNT_W'(CMDQ_DEPTH);
   assign head_cmd     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `MCEU_ASSERT_NEVER(a_push_into_full, clock, reset, push && status.full && !pop)
   `MCEU_ASSERT_NEVER(a_pop_from_empty, clock, reset, pop && status.empty)

endmodule

/* rtl/core/mce_back.sv */
`include "midi_controller_expander_unit_assert.svh"

module mce_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [6:0]               device_id,
   input  mce_pkg::cmdq_status_type q_status,
   input  mce_pkg::cmd_type         q_head,
   output logic                     q_pop,
   output logic                     empty,
   input  logic                     pop,
   output mce_pkg::rsp_type         rsp_data
);
   import mce_pkg::*;

   cmd_type    cur_ff, cur_in;
   logic [3:0] rem_ff, rem_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic [1:0] slot;
   logic [3:0] slot_bit;
   logic       slot_last;
   logic       emit;
   rsp_type    msg;

   // lowest pending slot goes out next
   always_comb begin
      if (rem_ff[0]) begin
         slot = 2'd0;
      end else if (rem_ff[1]) begin
         slot = 2'd1;
      end else if (rem_ff[2]) begin
         slot = 2'd2;
      end else begin
         slot = 2'd3;
      end
   end

   assign slot_bit  = 4'b0001 << slot;
   assign slot_last = (rem_ff & ~slot_bit) == 4'b0000;
   assign emit      = rem_ff != 4'b0000 && (!out_valid_ff || pop);
   assign q_pop     = !q_status.empty && (rem_ff == 4'b0000 || (emit && slot_last));

   always_comb begin
      msg               = expand_slot(cur_ff, slot);
      msg.out_device_id = device_id;
      msg.last          = slot_last;
   end

   always_comb begin
      cur_in       = q_pop ? q_head : cur_ff;
      rem_in       = rem_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         rem_in = slot_mask(q_head);
      end else if (emit) begin
         rem_in = rem_ff & ~slot_bit;
      end
      if (emit) begin
         out_in       = msg;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   `MCEU_ASSERT(a_last_drains_cmd, clock, reset, (emit && slot_last) |=> (rem_ff == 4'b0000 || $past(q_pop)))

endmodule

/* tb/tb_midi_controller_expander_unit.sv */
module tb_midi_controller_expander_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mce_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_PCT = 12;
   localparam int RANDOM_PER_PHASE = 24;

   // Last-value cache and message expansion, kept alongside the block.
   class expansion_scoreboard;
      rsp_type     pending_msgs[$];
      rsp_type     burst[$];
      int          errors;
      logic [6:0]  dev_id;
      logic [18:0] pitch_num;
      logic [18:0] prog_num;
      logic [18:0] mvol_num;
      bit          slot_live[CACHE_ENTRIES];
      logic [23:0] slot_key[CACHE_ENTRIES];
      logic [23:0] slot_val[CACHE_ENTRIES];

      function new();
         errors    = 0;
         dev_id    = 7'd127;
         pitch_num = 19'd262144;
         prog_num  = 19'd262145;
         mvol_num  = 19'd262146;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
      endfunction

      function void set_reg(input csr_index_type idx, input logic [18:0] v);
         case (idx)
            CSR_DEVICE_ID:    dev_id = v[6:0];
            CSR_PITCH_CTRL:   pitch_num = v;
            CSR_PROGRAM_CTRL: prog_num = v;
            CSR_MVOL_CTRL:    mvol_num = v;
            default: ;
         endcase
      endfunction

      function void add_msg(input msg_code_type code, input logic [7:0] st,
                            input logic [4:0] chn, input logic [18:0] da,
                            input logic [23:0] db);
         rsp_type m;
         m.message       = code;
         m.out_type      = st;
         m.out_channel   = chn;
         m.out_data_a    = da;
         m.out_data_b    = db;
         m.out_device_id = dev_id;
         m.last          = 1'b0;
         burst.push_back(m);
      endfunction

      function void add_cc(input logic [4:0] chn, input logic [18:0] num,
                           input logic [23:0] val);
         add_msg(MSG_CC, ST_CC, chn, num, val);
      endfunction

      // works out the messages one accepted word should yield
      function void note_word(input req_type w);
         int unsigned slot;
         logic [23:0] key;
         logic [18:0] a;
         logic [23:0] b;
         logic [4:0]  chn;
         logic [18:0] num_h, num_l, low_a;
         logic [23:0] num_hv, num_lv, val_h, val_l;
         burst.delete();
         a   = w.ctrl_number;
         b   = w.ctrl_value;
         chn = w.channel;
         if (w.event_type != CTRL_EVENT) begin
            add_msg(MSG_PASS, w.event_type, chn, a, b);
         end else begin
            key  = {chn, a};
            slot = (int'(a) ^ (int'(chn) << 5)) % CACHE_ENTRIES;
            if (slot_live[slot] && slot_key[slot] == key && slot_val[slot] == b) return;
            slot_live[slot] = 1'b1;
            slot_key[slot]  = key;
            slot_val[slot]  = b;
            num_h  = {12'd0, a[14:8]};
            num_l  = {12'd0, a[6:0]};
            num_hv = {17'd0, a[14:8]};
            num_lv = {17'd0, a[6:0]};
            val_h  = {17'd0, b[13:7]};
            val_l  = {17'd0, b[6:0]};
            low_a  = {12'd0, b[6:0]};
            if (a == pitch_num) begin
               add_msg(MSG_PITCH, ST_PITCH, chn, b[18:0], 24'd0);
            end else if (a == prog_num) begin
               if (b[23:16] != BANK_NONE) add_cc(chn, CC_BANK_H, {16'd0, b[23:16]});
               if (b[15:8] != BANK_NONE) add_cc(chn, CC_BANK_L, {16'd0, b[15:8]});
               add_msg(MSG_PROGRAM, ST_PROGRAM, chn, low_a, 24'd0);
            end else if (a == mvol_num) begin
               add_msg(MSG_SYSEX, ST_SYSEX, 5'd0, low_a, val_h);
            end else if (a < CLASS_CC14_BASE) begin
               add_cc(chn, a, b);
            end else if (a < CLASS_RPN_BASE) begin
               add_cc(chn, num_h, val_h);
               add_cc(chn, num_l, val_l);
            end else if (a < CLASS_NRPN_BASE) begin
               add_cc(chn, CC_RPN_H, num_hv);
               add_cc(chn, CC_RPN_L, num_lv);
               add_cc(chn, CC_DATA_H, b);
            end else if (a < CLASS_RPN14_BASE) begin
               add_cc(chn, CC_NRPN_H, num_hv);
               add_cc(chn, CC_NRPN_L, num_lv);
               add_cc(chn, CC_DATA_H, b);
            end else if (a < CLASS_NRPN14_BASE) begin
               add_cc(chn, CC_RPN_H, num_hv);
               add_cc(chn, CC_RPN_L, num_lv);
               add_cc(chn, CC_DATA_H, val_h);
               add_cc(chn, CC_DATA_L, val_l);
            end else if (a < CLASS_NONE_BASE) begin
               add_cc(chn, CC_NRPN_H, num_hv);
               add_cc(chn, CC_NRPN_L, num_lv);
               add_cc(chn, CC_DATA_H, val_h);
               add_cc(chn, CC_DATA_L, val_l);
            end
         end
         if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) pending_msgs.push_back(burst[i]);
      endfunction

      task report(input string what, input logic [23:0] got, input logic [23:0] want);
         errors++;
         $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      endtask

      task check_word(input rsp_type got);
         rsp_type want;
         if (pending_msgs.size() == 0) begin
            report("unexpected word, message", 24'(got.message), 24'd0);
            return;
         end
         want = pending_msgs.pop_front();
         if (got.message !== want.message)
            report("message", 24'(got.message), 24'(want.message));
         if (got.out_type !== want.out_type)
            report("out_type", 24'(got.out_type), 24'(want.out_type));
         if (got.out_channel !== want.out_channel)
            report("out_channel", 24'(got.out_channel), 24'(want.out_channel));
         if (got.out_data_a !== want.out_data_a)
            report("out_data_a", 24'(got.out_data_a), 24'(want.out_data_a));
         if (got.out_data_b !== want.out_data_b)
            report("out_data_b", got.out_data_b, want.out_data_b);
         if (got.out_device_id !== want.out_device_id)
            report("out_device_id", 24'(got.out_device_id), 24'(want.out_device_id));
         if (got.last !== want.last) report("last", 24'(got.last), 24'(want.last));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          push = 1'b0;
   logic          full;
   req_type       req_data = '0;
   logic          empty;
   logic          pop = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_DEVICE_ID;
   logic [18:0]   csr_wdata = '0;

   expansion_scoreboard sb;
   req_type recent[$];
   bit      steady = 1'b0;
   int      quiet_cycles = 0;

   midi_controller_expander_unit dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) sb.check_word(rsp_data);
         pop <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** midi_controller_expander_unit: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic req_type make_word(input logic [7:0] t, input logic [4:0] c,
                                         input logic [18:0] a, input logic [23:0] b);
      req_type w;
      w.event_type  = t;
      w.channel     = c;
      w.ctrl_number = a;
      w.ctrl_value  = b;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      w.event_type  = CTRL_EVENT;
      w.channel     = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                                : 5'($urandom_range(16));
      w.ctrl_value  = 24'($urandom);
      if ($urandom_range(3) == 0) w.ctrl_value = 24'($urandom_range(16'h3FFF));
      pick = $urandom_range(99);
      if (pick < 10) begin
         w.event_type  = 8'($urandom_range(255, 128));
         w.ctrl_number = 19'($urandom);
      end else if (pick < 30 && recent.size() > 0) begin
         // repeat a recent key, half the time with the same value
         w = recent[$urandom_range(recent.size() - 1)];
         if ($urandom_range(1)) w.ctrl_value = 24'($urandom);
      end else begin
         case ($urandom_range(9))
            0: w.ctrl_number = 19'($urandom_range(CLASS_CC14_BASE - 1, 0));
            1: w.ctrl_number = 19'($urandom_range(CLASS_RPN_BASE - 1, CLASS_CC14_BASE));
            2: w.ctrl_number = 19'($urandom_range(CLASS_NRPN_BASE - 1, CLASS_RPN_BASE));
            3: w.ctrl_number = 19'($urandom_range(CLASS_RPN14_BASE - 1, CLASS_NRPN_BASE));
            4: w.ctrl_number = 19'($urandom_range(CLASS_NRPN14_BASE - 1, CLASS_RPN14_BASE));
            5: w.ctrl_number = 19'($urandom_range(CLASS_NONE_BASE - 1, CLASS_NRPN14_BASE));
            6: w.ctrl_number = 19'($urandom_range(19'h7FFFF, CLASS_NONE_BASE));
            7: w.ctrl_number = sb.pitch_num;
            8: begin
               w.ctrl_number = sb.prog_num;
               if ($urandom_range(2) == 0) w.ctrl_value[23:16] = BANK_NONE;
               if ($urandom_range(2) == 0) w.ctrl_value[15:8] = BANK_NONE;
            end
            default: w.ctrl_number = sb.mvol_num;
         endcase
      end
      return w;
   endfunction

   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_word(w);
      if (w.event_type == CTRL_EVENT) begin
         recent.push_back(w);
         if (recent.size() > 16) void'(recent.pop_front());
      end
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_reg(input csr_index_type idx, input logic [18:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic write_config(input logic [6:0] dev, input logic [18:0] pn,
                               input logic [18:0] gn, input logic [18:0] mn);
      write_reg(CSR_DEVICE_ID, {12'd0, dev});
      write_reg(CSR_PITCH_CTRL, pn);
      write_reg(CSR_PROGRAM_CTRL, gn);
      write_reg(CSR_MVOL_CTRL, mn);
      csr_we <= 1'b0;
   endtask

   // words that hit the cache or have no class yield nothing, so allow extra time
   task automatic settle();
      push <= 1'b0;
      do @(posedge clock); while (sb.pending_msgs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset register values in force here
      send_word(make_word(8'd128, 5'd0, 19'h00000, 24'h000000));
      send_word(make_word(8'd255, 5'd31, 19'h7FFFF, 24'hFFFFFF));
      send_word(make_word(8'd177, 5'd16, 19'h00040, 24'h00007F));
      send_word(make_word(CTRL_EVENT, 5'd0, 19'h00007, 24'hFFFFFF));
      send_word(make_word(CTRL_EVENT, 5'd0, 19'h00007, 24'hFFFFFF));
      send_word(make_word(CTRL_EVENT, 5'd0, 19'h00007, 24'h000040));
      send_word(make_word(CTRL_EVENT, 5'd16, 19'h00FFF, 24'h000000));
      send_word(make_word(CTRL_EVENT, 5'd1, 19'h01000, 24'h003FFF));
      send_word(make_word(CTRL_EVENT, 5'd17, 19'h1FFFF, 24'hFFFF80));
      send_word(make_word(CTRL_EVENT, 5'd0, 19'h20000, 24'hABCDEF));
      send_word(make_word(CTRL_EVENT, 5'd31, 19'h3FFFF, 24'h00007F));
      send_word(make_word(CTRL_EVENT, 5'd2, 19'h40003, 24'h003FFF));
      send_word(make_word(CTRL_EVENT, 5'd3, 19'h5FFFF, 24'h00C000));
      send_word(make_word(CTRL_EVENT, 5'd4, 19'h60000, 24'h001234));
      send_word(make_word(CTRL_EVENT, 5'd5, 19'h6FFFF, 24'hFFFFFF));
      send_word(make_word(CTRL_EVENT, 5'd6, 19'h70000, 24'h000005));
      send_word(make_word(CTRL_EVENT, 5'd31, 19'h7FFFF, 24'h000000));
      send_word(make_word(CTRL_EVENT, 5'd0, 19'h40000, 24'hFFFFFF));
      send_word(make_word(CTRL_EVENT, 5'd0, 19'h40001, 24'hFFFF05));
      send_word(make_word(CTRL_EVENT, 5'd2, 19'h40001, 24'h80FF7F));
      send_word(make_word(CTRL_EVENT, 5'd3, 19'h40001, 24'hFF00FF));
      send_word(make_word(CTRL_EVENT, 5'd4, 19'h40001, 24'h010283));
      send_word(make_word(CTRL_EVENT, 5'd5, 19'h40002, 24'h003FFF));
      // two keys sharing one cache slot evict each other
      send_word(make_word(CTRL_EVENT, 5'd8, 19'h00005, 24'h000001));
      send_word(make_word(CTRL_EVENT, 5'd8, 19'h00405, 24'h000001));
      send_word(make_word(CTRL_EVENT, 5'd8, 19'h00005, 24'h000001));

      for (int phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: write_config(7'd0, 19'h7FFFF, 19'h40000, 19'h60000);
            1: write_config(7'd127, 19'h45678, 19'h45678, 19'h45678);
            2: write_config(7'($urandom_range(127)), 19'($urandom_range(524287, 262144)),
                            19'($urandom_range(524287, 262144)),
                            19'($urandom_range(524287, 262144)));
            default: write_config(7'h2A, 19'h40000, 19'h40001, 19'h40002);
         endcase
         steady = (phase == 2);
         repeat (RANDOM_PER_PHASE) send_word(random_word());
      end
      settle();

      if (sb.errors == 0) begin
         $display("** midi_controller_expander_unit: PASSED **");
      end else begin
         $display("** midi_controller_expander_unit: FAILED **");
      end
      $finish;
   end

endmodule
